// ===== rtl/core/birs_pkg.sv =====
// package with constants and types for the beat interval rate smoother
`timescale 1ns / 1ps

package birs_pkg;

  localparam int IV_W      = 16;
  localparam int RATE_W    = 20;
  localparam int RATE_NUM  = 600000;
  localparam int HIST_LEN  = 8;
  localparam int MID_COUNT = 4;

  localparam int MID_LO = (MID_COUNT >= HIST_LEN) ? 0 : (HIST_LEN - MID_COUNT) / 2;
  localparam int MID_HI_RAW = (MID_COUNT >= HIST_LEN) ? HIST_LEN
                                                      : (HIST_LEN + MID_COUNT) / 2;
  localparam int MID_HI  = (MID_HI_RAW > HIST_LEN) ? HIST_LEN : MID_HI_RAW;
  localparam int WIN_LEN = MID_HI - MID_LO;

  localparam int N_W     = $clog2(WIN_LEN + 1);
  localparam int SUM_W   = RATE_W + N_W;
  localparam int DIV_W   = SUM_W;
  localparam int STEP_W  = $clog2(DIV_W);
  localparam int SLOT_W  = $clog2(HIST_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_STORE,
    ST_SORT,
    ST_SUM,
    ST_DIV_MEAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/beat_interval_rate_smoother_top.sv =====
// beat interval to smoothed rate: shared divider, history ring, sort and middle mean
// one transaction at a time; the restoring divider (one quotient bit a cycle) is used twice
// a zero interval skips the first division and an all-zero middle window skips the second;
// a finished result waits in the output register while the next item is accepted; sync
// active-low reset clears ring, slot, control
`timescale 1ns / 1ps

module beat_interval_rate_smoother_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [birs_pkg::IV_W-1:0] in_interval_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [birs_pkg::RATE_W-1:0] out_rate_tenths_bpm
);
  import birs_pkg::*;

  state_t               state_r, state_nxt;
  logic [RATE_W-1:0]    hist_r [HIST_LEN];
  logic [RATE_W-1:0]    hist_nxt [HIST_LEN];
  logic [RATE_W-1:0]    sort_r [HIST_LEN];
  logic [RATE_W-1:0]    sort_nxt [HIST_LEN];
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [RATE_W-1:0]    rate_r, rate_nxt;
  logic [RATE_W-1:0]    res_r, res_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [N_W-1:0]       cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [IV_W-1:0]      rem_r, rem_nxt;
  logic [IV_W-1:0]      den_r, den_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0]    out_rate_r, out_rate_nxt;

  logic [IV_W:0]        rem_sh;
  logic                 qbit;
  logic [IV_W-1:0]      rem_step;
  logic [DIV_W-1:0]     dvd_step;
  logic [RATE_W-1:0]    cur_val;
  logic [SUM_W-1:0]     sum_upd;
  logic [N_W-1:0]       cnt_upd;

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_rate_tenths_bpm = out_rate_r;

  // shared restoring divider step
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DIV_W-1]};
    qbit     = (rem_sh >= {1'b0, den_r});
    rem_step = qbit ? IV_W'(rem_sh - {1'b0, den_r}) : rem_sh[IV_W-1:0];
    dvd_step = {dvd_r[DIV_W-2:0], qbit};
  end

  // middle window accumulate
  always_comb begin
    cur_val = sort_r[idx_r];
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    if (cur_val != '0) begin
      sum_upd = sum_r + SUM_W'(cur_val);
      cnt_upd = cnt_r + N_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hist_nxt      = hist_r;
    sort_nxt      = sort_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    rate_nxt      = rate_r;
    res_nxt       = res_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    step_nxt      = step_r;
    out_rate_nxt  = out_rate_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_interval_ms == '0) begin
            rate_nxt  = RATE_W'(RATE_NUM);
            state_nxt = ST_STORE;
          end else begin
            dvd_nxt   = DIV_W'(RATE_NUM);
            rem_nxt   = '0;
            den_nxt   = in_interval_ms;
            step_nxt  = '0;
            state_nxt = ST_DIV_RATE;
          end
        end
      end
      ST_DIV_RATE: begin
        dvd_nxt  = dvd_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          rate_nxt  = dvd_step[RATE_W-1:0];
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        hist_nxt[slot_r] = rate_r;
        for (int i = 0; i < HIST_LEN; i++) begin
          sort_nxt[i] = (SLOT_W'(i) == slot_r) ? rate_r : hist_r[i];
        end
        slot_nxt  = (slot_r == SLOT_W'(HIST_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
        idx_nxt   = '0;
        state_nxt = ST_SORT;
      end
      ST_SORT: begin
        // odd-even transposition, one phase per cycle
        for (int k = 0; k < HIST_LEN - 1; k++) begin
          if (((k % 2) == int'(idx_r[0])) && (sort_r[k] > sort_r[k+1])) begin
            sort_nxt[k]   = sort_r[k+1];
            sort_nxt[k+1] = sort_r[k];
          end
        end
        idx_nxt = idx_r + SLOT_W'(1);
        if (idx_r == SLOT_W'(HIST_LEN - 1)) begin
          idx_nxt   = SLOT_W'(MID_LO);
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
        idx_nxt = idx_r + SLOT_W'(1);
        if (idx_r == SLOT_W'(MID_HI - 1)) begin
          if (cnt_upd == '0) begin
            res_nxt   = rate_r;
            state_nxt = ST_DONE;
          end else begin
            dvd_nxt   = DIV_W'(sum_upd);
            rem_nxt   = '0;
            den_nxt   = IV_W'(cnt_upd);
            step_nxt  = '0;
            state_nxt = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        dvd_nxt  = dvd_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          res_nxt   = dvd_step[RATE_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
      hist_r      <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sort_r     <= sort_nxt;
    idx_r      <= idx_nxt;
    rate_r     <= rate_nxt;
    res_r      <= res_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    step_r     <= step_nxt;
    out_rate_r <= out_rate_nxt;
  end

endmodule

// ===== rtl/core/birs_checker.sv =====
// port-level checker for the beat interval rate smoother, with its bind
`timescale 1ns / 1ps

module birs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [birs_pkg::RATE_W-1:0] out_rate_tenths_bpm
);
  import birs_pkg::*;

  // result held until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rate_tenths_bpm))
    else $error("result dropped or changed while stalled");

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in progress");

  // no result in the cycle after an input transaction when none was pending
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // rate never exceeds saturation value
  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rate_tenths_bpm <= RATE_W'(RATE_NUM))
    else $error("rate out of range");

endmodule

bind beat_interval_rate_smoother_top birs_checker u_birs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_rate_tenths_bpm (out_rate_tenths_bpm)
);

// ===== tb/beat_interval_rate_smoother_top_tb.sv =====
// testbench for the beat interval rate smoother: queued driver, handshake monitor, rate predictor
`timescale 1ns / 1ps

module beat_interval_rate_smoother_top_tb;
  import birs_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES  = 128;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_PRINTS   = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IV_W-1:0]   in_interval_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RATE_W-1:0] out_rate_tenths_bpm;

  logic [IV_W-1:0]   interval_q[$];
  logic [RATE_W-1:0] smoothed_rate_q[$];
  logic [RATE_W-1:0] rate_ring [HIST_LEN];
  logic [SLOT_W-1:0] ring_slot = '0;

  logic in_taken = 1'b0;
  logic out_hold = 1'b0;
  logic hold_go = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;

  beat_interval_rate_smoother_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_interval_ms      (in_interval_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rate_tenths_bpm (out_rate_tenths_bpm)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    for (int i = 0; i < HIST_LEN; i++) rate_ring[i] = '0;
  end

  // converts one interval, updates the ring and returns the middle mean
  function automatic logic [RATE_W-1:0] smooth_rate(input logic [IV_W-1:0] iv);
    logic [RATE_W-1:0] raw;
    logic [RATE_W-1:0] srt [HIST_LEN];
    logic [RATE_W-1:0] tmp;
    logic [31:0]       acc;
    int                cnt;
    if (iv == '0) raw = RATE_W'(RATE_NUM);
    else raw = RATE_W'(32'(RATE_NUM) / 32'(iv));
    rate_ring[ring_slot] = raw;
    ring_slot = (ring_slot == SLOT_W'(HIST_LEN - 1)) ? '0 : ring_slot + SLOT_W'(1);
    for (int i = 0; i < HIST_LEN; i++) srt[i] = rate_ring[i];
    for (int i = 0; i < HIST_LEN - 1; i++) begin
      for (int j = 0; j < HIST_LEN - 1 - i; j++) begin
        if (srt[j] > srt[j + 1]) begin
          tmp = srt[j];
          srt[j] = srt[j + 1];
          srt[j + 1] = tmp;
        end
      end
    end
    acc = '0;
    cnt = 0;
    for (int i = MID_LO; i < MID_HI; i++) begin
      if (srt[i] != '0) begin
        acc = acc + 32'(srt[i]);
        cnt++;
      end
    end
    return (cnt != 0) ? RATE_W'(acc / 32'(cnt)) : raw;
  endfunction

  function automatic logic [IV_W-1:0] pick_interval();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return IV_W'($urandom_range(1500, 300));
    if (sel < 62) return IV_W'($urandom_range(2500, 200));
    if (sel < 67) return '0;
    if (sel < 72) return IV_W'($urandom_range(16, 1));
    return IV_W'($urandom_range(65535, 0));
  endfunction

  task automatic report_mismatch(input string what, input logic [RATE_W-1:0] got,
                                 input logic [RATE_W-1:0] want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic queue_item(input logic [IV_W-1:0] iv);
    interval_q.push_back(iv);
    n_queued++;
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (n_accepted != n_queued || n_checked != n_queued);
  endtask

  task automatic random_phase(input int n, input int send_idle, input int recv_stall,
                              input bit long_hold);
    @(posedge clk);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    repeat (n) queue_item(pick_interval());
    if (long_hold) hold_go = 1'b1;
    wait_drain();
  endtask

  // transaction driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (interval_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_interval_ms <= interval_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold = 1'b0;
  end

  // monitor and scoreboard
  always @(posedge clk) begin : scoreboard
    logic [RATE_W-1:0] want;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        smoothed_rate_q.push_back(smooth_rate(in_interval_ms));
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        if (smoothed_rate_q.size() == 0) begin
          report_mismatch("unexpected rate_tenths_bpm", out_rate_tenths_bpm, '0);
        end else begin
          want = smoothed_rate_q.pop_front();
          if (out_rate_tenths_bpm !== want)
            report_mismatch("rate_tenths_bpm", out_rate_tenths_bpm, want);
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: saturation and raw-rate outputs first, then extremes and a walking one
    @(posedge clk);
    queue_item('0);
    queue_item(16'hFFFF);
    queue_item(16'd1000);
    queue_item(16'd1);
    queue_item(16'd2);
    queue_item('0);
    for (int k = 0; k < IV_W; k++) queue_item(IV_W'(1) << k);
    queue_item(16'hAAAA);
    queue_item(16'h5555);
    wait_drain();

    random_phase(500, 0, 0, 1'b0);
    random_phase(500, 45, 0, 1'b0);
    random_phase(60, 0, 0, 1'b1);
    random_phase(500, 0, 45, 1'b0);
    random_phase(500, 20, 20, 1'b0);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && smoothed_rate_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== beat_interval_rate_smoother_top.f =====
rtl/core/birs_pkg.sv
rtl/core/beat_interval_rate_smoother_top.sv
rtl/core/birs_checker.sv
tb/beat_interval_rate_smoother_top_tb.sv
